// ===== hdl/sct_pkg.sv =====
package sct_pkg;

    localparam int ENTRIES     = 1024;
    localparam int IDX_W       = $clog2(ENTRIES);
    localparam int CREDIT_BITS = 48;
    localparam int ENTITY_W    = 10;
    localparam int TSC_W       = 64;
    localparam int SLOT_W      = 12;
    localparam int TX_W        = 32;
    localparam int TPS_W       = 24;
    localparam int SPS_W       = 11;
    localparam int CFG_DATA_W  = 24;
    localparam int LIMIT_W     = TPS_W + SPS_W;
    localparam int SAFE_LOG    = 40;
    localparam int MUL_A_W     = SAFE_LOG + 1;
    localparam int MUL_B_W     = SLOT_W;
    localparam int PROD_W      = MUL_A_W + MUL_B_W;
    localparam int SUM_W       = ((CREDIT_BITS > PROD_W) ? CREDIT_BITS : PROD_W) + 2;

    localparam logic [TSC_W-1:0] SAFE_DELTA = TSC_W'(1) << SAFE_LOG;
    localparam logic signed [CREDIT_BITS-1:0] CREDIT_MIN =
        {1'b1, {(CREDIT_BITS-1){1'b0}}};

    typedef enum logic [1:0] {
        CMD_REFILL      = 2'd0,
        CMD_CHARGE_TX   = 2'd1,
        CMD_CHARGE_SLOT = 2'd2,
        CMD_NONE        = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        EV_ADDED   = 3'd0,
        EV_CLAMPED = 3'd1,
        EV_RESET   = 3'd2,
        EV_CHARGED = 3'd3,
        EV_FLOORED = 3'd4
    } t_event;

    typedef enum logic [0:0] {
        CFG_TSC_PER_SLOT  = 1'b0,
        CFG_SLOTS_PER_SEQ = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DELTA,
        ST_MUL,
        ST_CHK,
        ST_WB
    } t_state;

    typedef struct packed {
        t_cmd                 command;
        logic [ENTITY_W-1:0]  entity;
        logic [TSC_W-1:0]     now_tsc;
        logic [SLOT_W-1:0]    slot_count;
        logic [TX_W-1:0]      tx_time;
    } t_in_item;

    typedef struct packed {
        logic signed [CREDIT_BITS-1:0] credit;
        t_event                        event_res;
    } t_out_item;

    typedef struct packed {
        logic                    rd_en;
        logic                    wr_credit_en;
        logic                    wr_stamp_en;
        logic [IDX_W-1:0]        addr;
        logic [CREDIT_BITS-1:0]  wr_credit;
        logic [TSC_W-1:0]        wr_stamp;
    } t_tbl_req;

    typedef struct packed {
        logic                    ready;
        logic [CREDIT_BITS-1:0]  credit;
        logic [TSC_W-1:0]        stamp;
    } t_tbl_rsp;

endpackage

// ===== hdl/shaper_credit_table.sv =====
// Shaping credit table: one signed credit and one refill stamp per entity.
// Input channel (i_in_valid / o_in_stall, payload i_in): one command per
// transfer: refill by elapsed time, charge by transmit time, or charge one
// full slot. Output channel (o_out_valid / i_out_stall, payload o_out): one
// result per command with the new credit and an event code.
// Config port (i_cfg_we / i_cfg_idx / i_cfg_data) writes tsc_per_slot and
// slots_per_seq; write only while the block is idle.
// Each command runs through a five-step sequencer around one shared
// 41x12 multiplier: table read, stamp delta and limit product, command
// product, limit check and add, then write-back. The result is registered
// at write-back, and the next command is taken only after write-back.
// The entry read-modify-write completes before the next command is taken.
// Reset: config registers return to 1, and a clearing pass zeroes all
// 1024 entries; o_in_stall stays high meanwhile.
// A stalled result holds in the output register; the next command may
// still be taken, and its write-back waits until the output register frees.
module shaper_credit_table (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [0:0]                     i_cfg_idx,
    input  logic [sct_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  sct_pkg::t_in_item              i_in,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output sct_pkg::t_out_item             o_out
);

    sct_pkg::t_state r_state, n_state;

    logic [sct_pkg::TPS_W-1:0]        r_tsc_per_slot;
    logic [sct_pkg::SPS_W-1:0]        r_slots_per_seq;
    sct_pkg::t_in_item                r_item;
    logic [sct_pkg::TSC_W-1:0]        r_delta;
    logic                             r_delta_big;
    logic [sct_pkg::LIMIT_W-1:0]      r_limit;
    logic [sct_pkg::PROD_W-1:0]       r_prod;
    logic                             r_reset;
    logic signed [sct_pkg::SUM_W-1:0] r_sum;
    logic                             r_out_valid;
    sct_pkg::t_out_item               r_out;

    sct_pkg::t_tbl_req                tbl_req;
    sct_pkg::t_tbl_rsp                tbl_rsp;

    logic [sct_pkg::MUL_A_W-1:0]      mul_a;
    logic [sct_pkg::MUL_B_W-1:0]      mul_b;
    logic [sct_pkg::PROD_W-1:0]       mul_p;
    logic                             in_xfer;
    logic                             out_free;
    logic                             wb_go;
    logic signed [sct_pkg::SUM_W-1:0] cr_ext;
    logic signed [sct_pkg::SUM_W-1:0] limit_ext;
    logic signed [sct_pkg::SUM_W-1:0] min_ext;
    sct_pkg::t_out_item               wb_res;

    sct_table u_table (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (tbl_req),
        .o_rsp  (tbl_rsp)
    );

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign wb_go    = (r_state == sct_pkg::ST_WB) && out_free;

    // shared multiplier: limit first, then the command's product
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            sct_pkg::ST_DELTA: begin
                mul_a = sct_pkg::MUL_A_W'(r_tsc_per_slot);
                mul_b = sct_pkg::MUL_B_W'(r_slots_per_seq);
            end
            sct_pkg::ST_MUL: begin
                unique case (r_item.command)
                    sct_pkg::CMD_REFILL: begin
                        mul_a = r_delta[sct_pkg::MUL_A_W-1:0];
                        mul_b = r_item.slot_count;
                    end
                    sct_pkg::CMD_CHARGE_TX: begin
                        mul_a = sct_pkg::MUL_A_W'(r_item.tx_time);
                        mul_b = sct_pkg::MUL_B_W'(r_slots_per_seq);
                    end
                    sct_pkg::CMD_CHARGE_SLOT: begin
                        mul_a = sct_pkg::MUL_A_W'(r_tsc_per_slot);
                        mul_b = sct_pkg::MUL_B_W'(r_slots_per_seq);
                    end
                    sct_pkg::CMD_NONE: begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    assign cr_ext    = sct_pkg::SUM_W'(signed'(tbl_rsp.credit));
    assign limit_ext = signed'(sct_pkg::SUM_W'(r_limit));
    assign min_ext   = sct_pkg::SUM_W'(sct_pkg::CREDIT_MIN);

    always_comb begin
        wb_res.credit    = r_sum[sct_pkg::CREDIT_BITS-1:0];
        wb_res.event_res = sct_pkg::EV_ADDED;
        unique case (r_item.command)
            sct_pkg::CMD_REFILL: begin
                if (r_reset) begin
                    wb_res.credit    = sct_pkg::CREDIT_BITS'(r_limit);
                    wb_res.event_res = sct_pkg::EV_RESET;
                end else if (r_sum > limit_ext) begin
                    wb_res.credit    = sct_pkg::CREDIT_BITS'(r_limit);
                    wb_res.event_res = sct_pkg::EV_CLAMPED;
                end else begin
                    wb_res.event_res = sct_pkg::EV_ADDED;
                end
            end
            sct_pkg::CMD_CHARGE_TX, sct_pkg::CMD_CHARGE_SLOT: begin
                if (r_sum < min_ext) begin
                    wb_res.credit    = sct_pkg::CREDIT_MIN;
                    wb_res.event_res = sct_pkg::EV_FLOORED;
                end else begin
                    wb_res.event_res = sct_pkg::EV_CHARGED;
                end
            end
            sct_pkg::CMD_NONE: begin
                wb_res.credit    = tbl_rsp.credit;
                wb_res.event_res = sct_pkg::EV_ADDED;
            end
        endcase
    end

    always_comb begin
        tbl_req.rd_en        = in_xfer;
        tbl_req.wr_credit_en = wb_go && (r_item.command != sct_pkg::CMD_NONE);
        tbl_req.wr_stamp_en  = wb_go && (r_item.command == sct_pkg::CMD_REFILL);
        tbl_req.addr         = (r_state == sct_pkg::ST_IDLE)
                               ? i_in.entity[sct_pkg::IDX_W-1:0]
                               : r_item.entity[sct_pkg::IDX_W-1:0];
        tbl_req.wr_credit    = wb_res.credit;
        tbl_req.wr_stamp     = r_item.now_tsc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sct_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_stall = 1'b1;
        unique case (r_state)
            sct_pkg::ST_CLEAR: begin
                if (tbl_rsp.ready) begin
                    n_state = sct_pkg::ST_IDLE;
                end
            end
            sct_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    n_state = sct_pkg::ST_DELTA;
                end
            end
            sct_pkg::ST_DELTA: n_state = sct_pkg::ST_MUL;
            sct_pkg::ST_MUL:   n_state = sct_pkg::ST_CHK;
            sct_pkg::ST_CHK:   n_state = sct_pkg::ST_WB;
            sct_pkg::ST_WB: begin
                if (out_free) begin
                    n_state = sct_pkg::ST_IDLE;
                end
            end
            default: n_state = sct_pkg::ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tsc_per_slot  <= sct_pkg::TPS_W'(1);
            r_slots_per_seq <= sct_pkg::SPS_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sct_pkg::CFG_TSC_PER_SLOT:  r_tsc_per_slot  <= i_cfg_data;
                sct_pkg::CFG_SLOTS_PER_SEQ:
                    r_slots_per_seq <= i_cfg_data[sct_pkg::SPS_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_item <= i_in;
        end
        if (r_state == sct_pkg::ST_DELTA) begin
            r_delta <= r_item.now_tsc - tbl_rsp.stamp;
            r_limit <= mul_p[sct_pkg::LIMIT_W-1:0];
        end
        if (r_state == sct_pkg::ST_MUL) begin
            r_prod      <= mul_p;
            r_delta_big <= r_delta > sct_pkg::SAFE_DELTA;
        end
        if (r_state == sct_pkg::ST_CHK) begin
            r_reset <= (r_item.slot_count != '0) &&
                       (r_delta_big ||
                        r_prod > sct_pkg::PROD_W'({r_limit, 1'b0}));
            if (r_item.command == sct_pkg::CMD_REFILL) begin
                r_sum <= cr_ext + signed'(sct_pkg::SUM_W'(r_prod));
            end else begin
                r_sum <= cr_ext - signed'(sct_pkg::SUM_W'(r_prod));
            end
        end
        if (wb_go) begin
            r_out <= wb_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (wb_go) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== hdl/sct_table.sv =====
module sct_table (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sct_pkg::t_tbl_req i_req,
    output sct_pkg::t_tbl_rsp o_rsp
);

    logic [sct_pkg::CREDIT_BITS-1:0] r_credit_mem [sct_pkg::ENTRIES];
    logic [sct_pkg::TSC_W-1:0]       r_stamp_mem  [sct_pkg::ENTRIES];
    logic [sct_pkg::CREDIT_BITS-1:0] r_rd_credit;
    logic [sct_pkg::TSC_W-1:0]       r_rd_stamp;
    logic [sct_pkg::IDX_W-1:0]       r_clr_cnt;
    logic                            r_clearing;

    // clearing pass: one entry per cycle after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt  <= '0;
            r_clearing <= 1'b1;
        end else if (r_clearing) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
            if (r_clr_cnt == sct_pkg::IDX_W'(sct_pkg::ENTRIES - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_credit_mem[r_clr_cnt] <= '0;
            r_stamp_mem[r_clr_cnt]  <= '0;
        end else begin
            if (i_req.wr_credit_en) begin
                r_credit_mem[i_req.addr] <= i_req.wr_credit;
            end
            if (i_req.wr_stamp_en) begin
                r_stamp_mem[i_req.addr] <= i_req.wr_stamp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_credit <= r_credit_mem[i_req.addr];
            r_rd_stamp  <= r_stamp_mem[i_req.addr];
        end
    end

    assign o_rsp.ready  = !r_clearing;
    assign o_rsp.credit = r_rd_credit;
    assign o_rsp.stamp  = r_rd_stamp;

endmodule

// ===== hdl/sct_checker.sv =====
module sct_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input sct_pkg::t_out_item o_out
);

    // one command in flight: stall rises right after a transfer
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while a command is in flight");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("stalled result dropped");

    a_limit_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out.event_res == sct_pkg::EV_CLAMPED ||
                         o_out.event_res == sct_pkg::EV_RESET))
        |-> !o_out.credit[sct_pkg::CREDIT_BITS-1])
        else $error("credit set to limit is negative");

    a_floor_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.event_res == sct_pkg::EV_FLOORED)
        |-> o_out.credit == sct_pkg::CREDIT_MIN)
        else $error("floored credit is not the minimum");

endmodule

bind shaper_credit_table sct_checker u_sct_checker (.*);
